/* rtl/mouse_accel_speed_multiplier_unit_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef MOUSE_ACCEL_SPEED_MULTIPLIER_UNIT_DEFINES_SVH
`define MOUSE_ACCEL_SPEED_MULTIPLIER_UNIT_DEFINES_SVH

// The consequent must hold in the clock after the antecedent.
`define MSM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same clock as the antecedent.
`define MSM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

`endif

/* rtl/msm_pkg.sv */
package msm_pkg;

	localparam int IN_W       = 56;
	localparam int OUT_W      = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DELTA_W    = 16;
	localparam int ELAPSED_W  = 20;
	localparam int Q_W        = 32;
	localparam int RATE_W     = 20;
	localparam int CPI_W      = 16;
	localparam int EXP_W      = 3;
	localparam int MFR_W      = 10;
	localparam int K_W        = 22;

	localparam logic [K_W-1:0]    K_CM_S     = 22'd2540000;
	localparam logic [K_W-1:0]    K_CNT_MS   = 22'd1000;
	localparam logic [RATE_W-1:0] MILLION    = 20'd1000000;
	localparam logic [MFR_W-1:0]  MFR_RESET  = 10'd125;
	localparam logic [EXP_W-1:0]  EXP_RESET  = 3'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS,
		REG_GAIN,
		REG_OFFSET,
		REG_CAP,
		REG_EXP,
		REG_CPI,
		REG_MFR
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_KLO,
		OP_KHI,
		OP_DEN,
		OP_DIVS_INIT,
		OP_DIV_STEP,
		OP_SPEED,
		OP_TMUL,
		OP_TTAKE,
		OP_POW_STEP,
		OP_MCALC,
		OP_DIVP_INIT,
		OP_POLL,
		OP_DIVF_INIT,
		OP_FRAME,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic close;
		logic last;
		logic pow_zero;
	} stat_t;

endpackage

/* rtl/msm_ctrl.sv */
module msm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output msm_pkg::op_t   op,
	input  msm_pkg::stat_t stat
);
	import msm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_SQX, ST_SQY, ST_SQI, ST_SQRT, ST_KLO, ST_KHI, ST_DEN,
		ST_DSI, ST_DIVS, ST_SPEED, ST_TMUL, ST_TTAKE, ST_POW, ST_MCALC, ST_DPI,
		ST_DIVP, ST_POLL, ST_DFI, ST_DIVF, ST_FRAME, ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		op       = OP_NONE;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op       = OP_LOAD;
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: state_nx = stat.close ? ST_SQX : ST_IDLE;
			ST_SQX: begin
				op       = OP_SQX;
				state_nx = ST_SQY;
			end
			ST_SQY: begin
				op       = OP_SQY;
				state_nx = ST_SQI;
			end
			ST_SQI: begin
				op       = OP_SQRT_INIT;
				state_nx = ST_SQRT;
			end
			ST_SQRT: begin
				op = OP_SQRT_STEP;
				if (stat.last) state_nx = ST_KLO;
			end
			ST_KLO: begin
				op       = OP_KLO;
				state_nx = ST_KHI;
			end
			ST_KHI: begin
				op       = OP_KHI;
				state_nx = ST_DEN;
			end
			ST_DEN: begin
				op       = OP_DEN;
				state_nx = ST_DSI;
			end
			ST_DSI: begin
				op       = OP_DIVS_INIT;
				state_nx = ST_DIVS;
			end
			ST_DIVS: begin
				op = OP_DIV_STEP;
				if (stat.last) state_nx = ST_SPEED;
			end
			ST_SPEED: begin
				op       = OP_SPEED;
				state_nx = ST_TMUL;
			end
			ST_TMUL: begin
				op       = OP_TMUL;
				state_nx = ST_TTAKE;
			end
			ST_TTAKE: begin
				op       = OP_TTAKE;
				state_nx = ST_POW;
			end
			ST_POW: begin
				if (stat.pow_zero) begin
					state_nx = ST_MCALC;
				end else begin
					op = OP_POW_STEP;
				end
			end
			ST_MCALC: begin
				op       = OP_MCALC;
				state_nx = ST_DPI;
			end
			ST_DPI: begin
				op       = OP_DIVP_INIT;
				state_nx = ST_DIVP;
			end
			ST_DIVP: begin
				op = OP_DIV_STEP;
				if (stat.last) state_nx = ST_POLL;
			end
			ST_POLL: begin
				op       = OP_POLL;
				state_nx = ST_DFI;
			end
			ST_DFI: begin
				op       = OP_DIVF_INIT;
				state_nx = ST_DIVF;
			end
			ST_DIVF: begin
				op = OP_DIV_STEP;
				if (stat.last) state_nx = ST_FRAME;
			end
			ST_FRAME: begin
				op       = OP_FRAME;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) begin
					op       = OP_EMIT;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/msm_dp.sv */
module msm_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [msm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [msm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [msm_pkg::DELTA_W-1:0] delta_x,
	input  logic signed [msm_pkg::DELTA_W-1:0] delta_y,
	input  logic [msm_pkg::ELAPSED_W-1:0]      elapsed_us,
	input  msm_pkg::op_t                       op,
	output msm_pkg::stat_t                     stat,
	output logic [msm_pkg::Q_W-1:0]            speed_q16,
	output logic [msm_pkg::Q_W-1:0]            multiplier_q16,
	output logic [msm_pkg::RATE_W-1:0]         poll_rate_hz,
	output logic [msm_pkg::RATE_W-1:0]         frame_rate_hz
);
	import msm_pkg::*;

	localparam int DW   = 32 + FRAC_BITS;
	localparam int RW   = 2 * DW;
	localparam int NW   = DW + K_W;
	localparam int DENW = 32 + CPI_W;
	localparam int CW   = $clog2(NW + 1);
	localparam logic [31:0] SENS_RST = 32'd4 << FRAC_BITS;
	localparam logic [31:0] ONE      = 32'd1 << FRAC_BITS;
	localparam logic [31:0] SAT      = '1;

	logic [31:0]        sens_q, gain_q, off_q, cap_q;
	logic [EXP_W-1:0]   exp_q;
	logic [CPI_W-1:0]   cpi_q;
	logic [MFR_W-1:0]   mfr_q;
	logic [31:0]        sum_x_q, sum_y_q, win_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [63:0]        s_q;
	logic [RW-1:0]      rad_q;
	logic [DW+1:0]      rem_q;
	logic [DW-1:0]      root_q;
	logic [NW-1:0]      num_q, dnum_q;
	logic [DENW-1:0]    den_q, drem_q;
	logic [31:0]        quo_q;
	logic               over_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        speed_q, t_q, a_q, mult_q;
	logic [RATE_W-1:0]  poll_q, frame_q;
	logic [31:0]        out_speed_q, out_mult_q;
	logic [RATE_W-1:0]  out_poll_q, out_frame_q;

	logic [31:0]        mx, my, mul_a, mul_b, sh_sat, win_nz, m_sum_sat, m_sel;
	logic [63:0]        prod, sh;
	logic [32:0]        w_sum, win_p, m_sum;
	logic [42:0]        close_prod;
	logic [K_W-1:0]     k;
	logic [DW+3:0]      rem2, trial;
	logic               sq_ge, div_ge;
	logic [DENW:0]      r2;
	logic [CPI_W-1:0]   cpi_nz;
	logic [ELAPSED_W-1:0] el_nz;

	assign mx     = sum_x_q[31] ? (~sum_x_q + 32'd1) : sum_x_q;
	assign my     = sum_y_q[31] ? (~sum_y_q + 32'd1) : sum_y_q;
	assign win_nz = (win_q == 32'd0) ? 32'd1 : win_q;
	assign cpi_nz = (cpi_q == '0) ? CPI_W'(1) : cpi_q;
	assign el_nz  = (elapsed_q == '0) ? ELAPSED_W'(1) : elapsed_q;
	assign k      = (cpi_q != '0) ? K_CM_S : K_CNT_MS;
	assign w_sum  = {1'b0, win_q} + {13'd0, elapsed_us};
	assign win_p  = {1'b0, win_q} + 33'd1000;
	assign close_prod = 43'(win_p) * 43'(mfr_q);

	assign stat.close    = close_prod > 43'd1000000;
	assign stat.last     = (cnt_q == CW'(1));
	assign stat.pow_zero = (cnt_q == '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_SQX: begin
				mul_a = mx;
				mul_b = mx;
			end
			OP_SQY: begin
				mul_a = my;
				mul_b = my;
			end
			OP_KLO: begin
				mul_a = root_q[31:0];
				mul_b = 32'(k);
			end
			OP_KHI: begin
				mul_a = 32'(root_q[DW-1:32]);
				mul_b = 32'(k);
			end
			OP_DEN: begin
				mul_a = win_nz;
				mul_b = 32'(cpi_nz);
			end
			OP_TMUL: begin
				mul_a = gain_q;
				mul_b = speed_q - off_q;
			end
			OP_POW_STEP: begin
				mul_a = a_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = 64'(mul_a) * 64'(mul_b);
	assign sh     = prod >> FRAC_BITS;
	assign sh_sat = (sh[63:32] != 32'd0) ? SAT : sh[31:0];

	assign rem2  = {rem_q, rad_q[RW-1 -: 2]};
	assign trial = (DW+4)'({root_q, 2'b01});
	assign sq_ge = rem2 >= trial;

	assign r2     = {drem_q, dnum_q[NW-1]};
	assign div_ge = r2 >= {1'b0, den_q};

	assign m_sum     = {1'b0, sens_q} + {1'b0, a_q};
	assign m_sum_sat = m_sum[32] ? SAT : m_sum[31:0];
	assign m_sel     = (off_q > speed_q) ? sens_q : m_sum_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RST;
			gain_q  <= '0;
			off_q   <= '0;
			cap_q   <= '0;
			exp_q   <= EXP_RESET;
			cpi_q   <= '0;
			mfr_q   <= MFR_RESET;
			sum_x_q <= '0;
			sum_y_q <= '0;
			win_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SENS:   sens_q <= cfg_data;
					REG_GAIN:   gain_q <= cfg_data;
					REG_OFFSET: off_q  <= cfg_data;
					REG_CAP:    cap_q  <= cfg_data;
					REG_EXP:    exp_q  <= cfg_data[EXP_W-1:0];
					REG_CPI:    cpi_q  <= cfg_data[CPI_W-1:0];
					REG_MFR:    mfr_q  <= cfg_data[MFR_W-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_LOAD: begin
					sum_x_q <= sum_x_q + 32'(delta_x);
					sum_y_q <= sum_y_q + 32'(delta_y);
					win_q   <= w_sum[32] ? SAT : w_sum[31:0];
				end
				OP_SQRT_INIT: cnt_q <= CW'(DW);
				OP_SQRT_STEP: cnt_q <= cnt_q - CW'(1);
				OP_DIVS_INIT: cnt_q <= CW'(NW);
				OP_DIVP_INIT: cnt_q <= CW'(RATE_W);
				OP_DIVF_INIT: cnt_q <= CW'(RATE_W);
				OP_DIV_STEP:  cnt_q <= cnt_q - CW'(1);
				OP_TTAKE:     cnt_q <= CW'(exp_q);
				OP_POW_STEP:  cnt_q <= cnt_q - CW'(1);
				OP_EMIT: begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					win_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: elapsed_q <= elapsed_us;
			OP_SQX:  s_q <= prod;
			OP_SQY:  s_q <= s_q + prod;
			OP_SQRT_INIT: begin
				rad_q  <= {s_q, (2*FRAC_BITS)'(0)};
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ge ? (DW+2)'(rem2 - trial) : (DW+2)'(rem2);
				root_q <= {root_q[DW-2:0], sq_ge};
			end
			OP_KLO: num_q <= NW'(prod);
			OP_KHI: num_q <= num_q + (NW'(prod) << 32);
			OP_DEN: den_q <= prod[DENW-1:0];
			OP_DIVS_INIT: begin
				dnum_q <= num_q;
				drem_q <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
			end
			OP_DIVP_INIT: begin
				dnum_q <= {MILLION, (NW-RATE_W)'(0)};
				den_q  <= DENW'(el_nz);
				drem_q <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
			end
			OP_DIVF_INIT: begin
				dnum_q <= {MILLION, (NW-RATE_W)'(0)};
				den_q  <= DENW'(win_nz);
				drem_q <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
			end
			OP_DIV_STEP: begin
				dnum_q <= dnum_q << 1;
				drem_q <= div_ge ? DENW'(r2 - {1'b0, den_q}) : r2[DENW-1:0];
				quo_q  <= {quo_q[30:0], div_ge};
				over_q <= over_q | quo_q[31];
			end
			OP_SPEED:    speed_q <= over_q ? SAT : quo_q;
			OP_TMUL:     t_q <= sh_sat;
			OP_TTAKE:    a_q <= ONE;
			OP_POW_STEP: a_q <= sh_sat;
			OP_MCALC:    mult_q <= ((cap_q != 32'd0) && (m_sel > cap_q)) ? cap_q : m_sel;
			OP_POLL:     poll_q <= quo_q[RATE_W-1:0];
			OP_FRAME:    frame_q <= quo_q[RATE_W-1:0];
			OP_EMIT: begin
				out_speed_q <= speed_q;
				out_mult_q  <= mult_q;
				out_poll_q  <= poll_q;
				out_frame_q <= frame_q;
			end
			default: ;
		endcase
	end

	assign speed_q16      = out_speed_q;
	assign multiplier_q16 = out_mult_q;
	assign poll_rate_hz   = out_poll_q;
	assign frame_rate_hz  = out_frame_q;

endmodule

/* rtl/mouse_accel_speed_multiplier_unit.sv */
// Channel | Direction | Handshake                      | Payload
// s_axis  | in        | s_axis_tvalid / s_axis_tready  | mouse report
// m_axis  | out       | m_axis_tvalid / m_axis_tready  | speed, multiplier, rates
// cfg     | in        | cfg_valid / cfg_ready          | register index and data
//
// A report that does not close the window is accumulated and checked, then the block
// idles. A closing report runs the bit-serial square root (32 + FRAC_BITS steps), the
// shared restoring divider (54 + FRAC_BITS steps for speed, 20 each for the two rates)
// and one multiply per exponent step. The result sits in an output register, so the
// next report is taken while it waits; a stalled result holds the block only at the
// next emission. Reset is asynchronous and restores the defaults and empty accumulators.
module mouse_accel_speed_multiplier_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// delta_x [15:0], delta_y [31:16], elapsed_us [51:32], zero fill [55:52]
	input  logic [msm_pkg::IN_W-1:0]          s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// speed_q16 [31:0], multiplier_q16 [63:32], poll_rate_hz [83:64],
	// frame_rate_hz [103:84]
	output logic [msm_pkg::OUT_W-1:0]         m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [msm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import msm_pkg::*;

	op_t               op;
	stat_t             stat;
	logic [Q_W-1:0]    speed, mult;
	logic [RATE_W-1:0] poll, frame;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {frame, poll, mult, speed};

	msm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.op        (op),
		.stat      (stat)
	);

	msm_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.delta_x        (s_axis_tdata[15:0]),
		.delta_y        (s_axis_tdata[31:16]),
		.elapsed_us     (s_axis_tdata[51:32]),
		.op             (op),
		.stat           (stat),
		.speed_q16      (speed),
		.multiplier_q16 (mult),
		.poll_rate_hz   (poll),
		.frame_rate_hz  (frame)
	);

endmodule

/* rtl/msm_chk.sv */
`include "mouse_accel_speed_multiplier_unit_defines.svh"

module msm_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [msm_pkg::OUT_W-1:0] m_axis_tdata
);
	import msm_pkg::*;

	`MSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`MSM_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`MSM_ASSERT_NOW(a_poll_range, m_axis_tvalid, m_axis_tdata[83:64] <= MILLION)
	`MSM_ASSERT_NOW(a_frame_range, m_axis_tvalid, m_axis_tdata[103:84] <= MILLION)

endmodule

bind mouse_accel_speed_multiplier_unit msm_chk u_msm_chk (.*);

/* bench/tb_mouse_accel_speed_multiplier_unit.sv */
`timescale 1ns / 1ps

module tb_mouse_accel_speed_multiplier_unit;
	import msm_pkg::*;

	localparam int FRAC = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef struct {
		logic [31:0] speed;
		logic [31:0] mult;
		logic [19:0] poll;
		logic [19:0] frame;
	} window_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [IN_W-1:0] report_q[$];
	window_result_t window_q[$];

	logic [31:0] sens, gain, offset, cap;
	logic [2:0] exponent;
	logic [15:0] cpi;
	logic [9:0] frame_rate;
	logic [31:0] acc_x, acc_y, acc_win;

	int snd_idle;
	int rcv_idle;
	int hold_cnt;
	int idle_cycles;
	int errors;
	int n_reports;
	int n_windows;

	mouse_accel_speed_multiplier_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [32:0] abs_sum(logic [31:0] v);
		if (v[31]) begin
			return {1'b0, ~v} + 33'd1;
		end
		return {1'b0, v};
	endfunction

	function automatic logic [31:0] sat32(logic [127:0] v);
		return (v > {96'd0, MAX32}) ? MAX32 : v[31:0];
	endfunction

	function automatic void predict_report(logic [IN_W-1:0] d);
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [19:0] el;
		logic [32:0] mx, my;
		logic [127:0] w, sq, root, trial, num, den, t, a, m;
		logic [31:0] speed;
		window_result_t r;
		dx = d[15:0];
		dy = d[31:16];
		el = d[51:32];
		acc_x = acc_x + {{16{dx[15]}}, dx};
		acc_y = acc_y + {{16{dy[15]}}, dy};
		w = {96'd0, acc_win} + {108'd0, el};
		acc_win = sat32(w);
		w = {96'd0, acc_win};
		if ((w + 128'd1000) * frame_rate <= 128'd1000000) begin
			return;
		end
		mx = abs_sum(acc_x);
		my = abs_sum(acc_y);
		sq = ({95'd0, mx} * mx + {95'd0, my} * my) << (2 * FRAC);
		root = 0;
		for (int b = 56; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sq) begin
				root = trial;
			end
		end
		den = (w == 0) ? 128'd1 : w;
		if (cpi != 0) begin
			num = root * K_CM_S;
			den = den * cpi;
		end else begin
			num = root * K_CNT_MS;
		end
		speed = sat32(num / den);
		if (offset > speed) begin
			m = {96'd0, sens};
		end else begin
			t = {96'd0, sat32(({96'd0, gain} * (speed - offset)) >> FRAC)};
			a = 128'd1 << FRAC;
			for (int i = 0; i < exponent; i++) begin
				a = {96'd0, sat32((a * t) >> FRAC)};
			end
			m = {96'd0, sat32({96'd0, sens} + a)};
		end
		if (cap != 0 && m > cap) begin
			m = {96'd0, cap};
		end
		r.speed = speed;
		r.mult = m[31:0];
		r.poll = (el == 0) ? MILLION : 20'(1000000 / el);
		r.frame = (w == 0) ? MILLION : 20'(128'd1000000 / w);
		window_q.push_back(r);
		acc_x = 0;
		acc_y = 0;
		acc_win = 0;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch on window %0d, %s: expected %h, got %h", n_windows, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_report(s_axis_tdata);
			n_reports++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (report_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
				s_axis_tdata <= report_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		window_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (window_q.size() == 0) begin
				report_mismatch("unexpected beat", 32'd0, m_axis_tdata[31:0]);
			end else begin
				e = window_q.pop_front();
				if (m_axis_tdata[31:0] !== e.speed)
					report_mismatch("speed_q16", e.speed, m_axis_tdata[31:0]);
				if (m_axis_tdata[63:32] !== e.mult)
					report_mismatch("multiplier_q16", e.mult, m_axis_tdata[63:32]);
				if (m_axis_tdata[83:64] !== e.poll)
					report_mismatch("poll_rate_hz", 32'(e.poll), 32'(m_axis_tdata[83:64]));
				if (m_axis_tdata[103:84] !== e.frame)
					report_mismatch("frame_rate_hz", 32'(e.frame), 32'(m_axis_tdata[103:84]));
			end
			n_windows++;
		end
		m_axis_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SENS: sens = value;
			REG_GAIN: gain = value;
			REG_OFFSET: offset = value;
			REG_CAP: cap = value;
			REG_EXP: exponent = value[2:0];
			REG_CPI: cpi = value[15:0];
			REG_MFR: frame_rate = value[9:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		@(posedge clk);
		while (report_q.size() > 0 || s_axis_tvalid || window_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pack_report(int dx, int dy, int el);
		logic [15:0] x, y;
		logic [19:0] e;
		x = 16'(dx);
		y = 16'(dy);
		e = 20'(el);
		return {4'd0, e, y, x};
	endfunction

	function automatic logic [31:0] pick32(logic [31:0] typ_hi);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return MAX32;
			2: return $urandom;
			default: return $urandom_range(0, typ_hi);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] random_report(int period);
		int span;
		span = $urandom_range(0, 9);
		if (span == 0) begin
			return pack_report($urandom, $urandom, $urandom_range(0, 1048575));
		end
		if (span == 1) begin
			return pack_report($urandom, $urandom, 0);
		end
		return pack_report($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
			$urandom_range(0, period / 4 + 1));
	endfunction

	initial begin
		int period;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SENS;
		cfg_data = '0;
		snd_idle = 6;
		rcv_idle = 72;
		hold_cnt = 0;
		idle_cycles = 0;
		errors = 0;
		n_reports = 0;
		n_windows = 0;
		sens = 32'd4 << FRAC;
		gain = 0;
		offset = 0;
		cap = 0;
		exponent = EXP_RESET;
		cpi = 0;
		frame_rate = MFR_RESET;
		acc_x = 0;
		acc_y = 0;
		acc_win = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		report_q.push_back(pack_report(32767, -32768, 0));
		report_q.push_back(pack_report(-32768, 32767, 1));
		report_q.push_back(pack_report(0, 0, 1048575));
		report_q.push_back(pack_report(1, -1, 7001));
		report_q.push_back(pack_report(-1, 1, 500));
		report_q.push_back(pack_report(0, 0, 6600));
		drain();

		write_reg(REG_MFR, 1023);
		write_reg(REG_EXP, 0);
		write_reg(REG_CPI, 1);
		report_q.push_back(pack_report(-32768, -32768, 0));
		report_q.push_back(pack_report(0, 0, 0));
		report_q.push_back(pack_report(32767, 32767, 0));
		drain();

		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_MFR, 1000);
		write_reg(REG_CPI, 65535);
		write_reg(REG_SENS, MAX32);
		write_reg(REG_GAIN, MAX32);
		write_reg(REG_OFFSET, 0);
		write_reg(REG_CAP, MAX32 - 1);
		write_reg(REG_EXP, 7);
		report_q.push_back(pack_report(32767, -32768, 1));
		report_q.push_back(pack_report(-32768, 0, 1048575));
		report_q.push_back(pack_report(100, 100, 1000));
		drain();

		write_reg(REG_SENS, 32'd1 << FRAC);
		write_reg(REG_GAIN, 32'd1 << (FRAC - 2));
		write_reg(REG_OFFSET, 32'd2 << FRAC);
		write_reg(REG_CAP, 32'd3 << FRAC);
		write_reg(REG_EXP, 2);
		write_reg(REG_CPI, 0);
		report_q.push_back(pack_report(1, 0, 1000));
		report_q.push_back(pack_report(3000, 4000, 1000));
		report_q.push_back(pack_report(30, 40, 1000));
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 4) begin
				snd_idle = 72;
				rcv_idle = 6;
			end else if (ph == 7) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			write_reg(REG_SENS, pick32(32'd8 << FRAC));
			write_reg(REG_GAIN, pick32(32'd4 << FRAC));
			write_reg(REG_OFFSET, pick32(32'd64 << FRAC));
			write_reg(REG_CAP, ($urandom_range(0, 1) == 0) ? 32'd0 : pick32(32'd16 << FRAC));
			write_reg(REG_EXP, $urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: write_reg(REG_CPI, 0);
				1: write_reg(REG_CPI, 65535);
				default: write_reg(REG_CPI, $urandom_range(1, 65535));
			endcase
			case (ph % 4)
				0: write_reg(REG_MFR, 1000);
				1: write_reg(REG_MFR, $urandom_range(1, 20));
				default: write_reg(REG_MFR, $urandom_range(60, 1023));
			endcase
			period = (frame_rate == 0) ? 1000 : 1000000 / frame_rate;
			for (int i = 0; i < 50; i++) begin
				report_q.push_back(random_report(period));
			end
			if (ph == 2) begin
				@(negedge clk);
				hold_cnt = 1500;
			end
			drain();
		end

		write_reg(REG_MFR, 0);
		for (int i = 0; i < 20; i++) begin
			report_q.push_back(pack_report(32767, -32768, 1048575));
		end
		drain();
		write_reg(REG_MFR, 1);
		report_q.push_back(pack_report(0, 0, 5));
		drain();

		$display("Checked %0d windows from %0d mouse reports, including saturating results,",
			n_windows, n_reports);
		$display("zero-length windows, a window that never closes and register extremes.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
